FILE: hdl/tlv_stream_parser_crc_check_top_assert.svh
// assertion macros for the tlv stream parser checker
// no dependencies; included by the checker file only
`ifndef TLV_STREAM_PARSER_CRC_CHECK_TOP_ASSERT_SVH
`define TLV_STREAM_PARSER_CRC_CHECK_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TSPC_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tspc assertion failed");

// next-cycle implication, disabled while in reset
`define TSPC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tspc assertion failed");

`endif

FILE: hdl/tspc_pkg.sv
// shared types, codes and the crc-32 byte update for the tlv stream parser
// no dependencies
package tspc_pkg;

	localparam int MAX_RECORDS_DEFAULT = 16;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [2:0] ST_PROGRESS  = 3'd0;
	localparam logic [2:0] ST_SUCCESS   = 3'd1;
	localparam logic [2:0] ST_TOO_MANY  = 3'd2;
	localparam logic [2:0] ST_TRUNCATED = 3'd3;
	localparam logic [2:0] ST_MISMATCH  = 3'd4;

	localparam logic [1:0] ROLE_TYPE   = 2'd0;
	localparam logic [1:0] ROLE_LEN_HI = 2'd1;
	localparam logic [1:0] ROLE_LEN_LO = 2'd2;
	localparam logic [1:0] ROLE_VALUE  = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [3:0]  record_index;
		logic [7:0]  record_type;
		logic [1:0]  byte_role;
		logic [15:0] value_offset;
		logic [15:0] record_length;
		logic        record_done;
		logic [2:0]  status;
		logic        message_end;
	} result_t;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: hdl/tlv_stream_parser_crc_check_top.sv
// tlv stream parser with crc-32 checksum records
// an accepted request passes the input register, then the result register, to the result port
// throughput: one byte per cycle unless m_tready stalls; the parser state updates as each byte
// enters the result register, and the result and input registers together decouple the two sides
// reset (arst_n low) clears the parser to expecting a type byte, crc all ones, valid flags to zero
// depends on tspc_pkg, tspc_in_stage, tspc_parser
module tlv_stream_parser_crc_check_top #(
	parameter int MAX_RECORDS = tspc_pkg::MAX_RECORDS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,    // checksum_record_type
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // [7:0] data_byte
	input  logic        s_tlast,      // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] byte_out, [11:8] record_index, [19:12] record_type, [35:20] value_offset,
	// [51:36] record_length, [52] record_done, [55:53] status
	output logic [55:0] m_tdata,
	output logic [1:0]  m_tuser,      // [1:0] byte_role
	output logic        m_tlast       // message_end
);

	logic              advance;
	logic              valid_s1;
	tspc_pkg::item_t   item_s1;
	tspc_pkg::result_t res;
	tspc_pkg::result_t res_q;
	logic              m_valid_q;
	logic              step;

	assign advance = !m_valid_q || m_tready;
	assign step    = valid_s1 && advance;

	tspc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tspc_parser #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item      (item_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {res_q.status, res_q.record_done, res_q.record_length,
		res_q.value_offset, res_q.record_type, res_q.record_index, res_q.byte_out};
	assign m_tuser  = res_q.byte_role;
	assign m_tlast  = res_q.message_end;

endmodule

FILE: hdl/tspc_in_stage.sv
// input register stage of the tlv stream parser
// depends on tspc_pkg
module tspc_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,
	input  logic            s_tlast,
	input  logic            advance,
	output logic            valid_s1,
	output tspc_pkg::item_t item_s1
);

	logic valid_q;
	tspc_pkg::item_t item_q;

	// the held request leaves whenever the result register can take it
	assign s_tready = !valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q.data_byte <= s_tdata;
			item_q.last_byte <= s_tlast;
		end
	end

	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

endmodule

FILE: hdl/tspc_parser.sv
// record parser state, crc tracking and per-byte annotation
// depends on tspc_pkg (codes, structs, crc32_byte)
module tspc_parser #(
	parameter int MAX_RECORDS = tspc_pkg::MAX_RECORDS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [7:0]        cfg_wdata,
	input  logic              step,
	input  tspc_pkg::item_t   item,
	output tspc_pkg::result_t res
);

	localparam int RW = $clog2(MAX_RECORDS + 1);

	typedef enum logic [1:0] {
		PH_TYPE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_VALUE
	} phase_t;

	logic [7:0]  csum_type_q;
	phase_t      phase_q, phase_d;
	logic [RW-1:0] recs_q, recs_d;
	logic [7:0]  cur_type_q, cur_type_d;
	logic [15:0] len_q, len_d;
	logic [15:0] seen_q, seen_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] exp_q, exp_d;
	logic        cmp_ok_q, cmp_ok_d;
	logic        failed_q, failed_d;

	logic [7:0]  d;
	logic        last;
	logic        done;
	logic [2:0]  st;
	logic [7:0]  want;

	assign d    = item.data_byte;
	assign last = item.last_byte;

	always_comb begin
		case (seen_q[1:0])
			2'd0: want = exp_q[31:24];
			2'd1: want = exp_q[23:16];
			2'd2: want = exp_q[15:8];
			default: want = exp_q[7:0];
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		recs_d     = recs_q;
		cur_type_d = cur_type_q;
		len_d      = len_q;
		seen_d     = seen_q;
		crc_d      = crc_q;
		exp_d      = exp_q;
		cmp_ok_d   = cmp_ok_q;
		failed_d   = failed_q;
		done       = 1'b0;
		st         = tspc_pkg::ST_PROGRESS;

		res               = '0;
		res.byte_out      = d;
		res.message_end   = last;

		if (!failed_q) begin
			res.record_index = 4'(recs_q);
			case (phase_q)
				PH_TYPE: begin
					res.byte_role   = tspc_pkg::ROLE_TYPE;
					res.record_type = d;
					if (recs_q >= RW'(MAX_RECORDS)) begin
						st = tspc_pkg::ST_TOO_MANY;
					end else begin
						cur_type_d = d;
						len_d      = '0;
						phase_d    = PH_LEN_HI;
						if (last) begin
							st = tspc_pkg::ST_TRUNCATED;
						end
					end
				end
				PH_LEN_HI: begin
					res.byte_role   = tspc_pkg::ROLE_LEN_HI;
					res.record_type = cur_type_q;
					len_d           = {d, 8'd0};
					phase_d         = PH_LEN_LO;
					if (last) begin
						st = tspc_pkg::ST_TRUNCATED;
					end
				end
				PH_LEN_LO: begin
					res.byte_role     = tspc_pkg::ROLE_LEN_LO;
					res.record_type   = cur_type_q;
					len_d             = {len_q[15:8], d};
					res.record_length = len_d;
					exp_d             = ~crc_q;
					cmp_ok_d          = 1'b1;
					seen_d            = '0;
					if (len_d == 16'd0) begin
						done = 1'b1;
					end else begin
						phase_d = PH_VALUE;
						if (last) begin
							st = tspc_pkg::ST_TRUNCATED;
						end
					end
				end
				default: begin
					res.byte_role     = tspc_pkg::ROLE_VALUE;
					res.record_type   = cur_type_q;
					res.record_length = len_q;
					res.value_offset  = seen_q;
					crc_d             = tspc_pkg::crc32_byte(crc_q, d);
					// only the first four value bytes carry the checksum
					if (seen_q < 16'd4 && want != d) begin
						cmp_ok_d = 1'b0;
					end
					seen_d = seen_q + 16'd1;
					if (seen_d == len_q) begin
						done = 1'b1;
					end else if (last) begin
						st = tspc_pkg::ST_TRUNCATED;
					end
				end
			endcase

			if (done) begin
				if (cur_type_d == csum_type_q && (len_d < 16'd4 || !cmp_ok_d)) begin
					st = tspc_pkg::ST_MISMATCH;
				end else begin
					recs_d  = recs_q + RW'(1);
					phase_d = PH_TYPE;
					if (last) begin
						st = tspc_pkg::ST_SUCCESS;
					end
				end
			end
			if (st >= tspc_pkg::ST_TOO_MANY) begin
				failed_d = 1'b1;
			end
			res.record_done = done;
			res.status      = st;
		end

		// end of message returns the parser to its idle state
		if (last) begin
			phase_d    = PH_TYPE;
			recs_d     = '0;
			cur_type_d = '0;
			len_d      = '0;
			seen_d     = '0;
			crc_d      = tspc_pkg::CRC_INIT;
			exp_d      = '0;
			cmp_ok_d   = 1'b1;
			failed_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_type_q <= '0;
			phase_q     <= PH_TYPE;
			recs_q      <= '0;
			cur_type_q  <= '0;
			len_q       <= '0;
			seen_q      <= '0;
			crc_q       <= tspc_pkg::CRC_INIT;
			exp_q       <= '0;
			cmp_ok_q    <= 1'b1;
			failed_q    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				csum_type_q <= cfg_wdata;
			end
			if (step) begin
				phase_q    <= phase_d;
				recs_q     <= recs_d;
				cur_type_q <= cur_type_d;
				len_q      <= len_d;
				seen_q     <= seen_d;
				crc_q      <= crc_d;
				exp_q      <= exp_d;
				cmp_ok_q   <= cmp_ok_d;
				failed_q   <= failed_d;
			end
		end
	end

endmodule

FILE: hdl/tspc_checker.sv
// port-level checks for the tlv stream parser, bound to the top level
// depends on tspc_pkg and tlv_stream_parser_crc_check_top_assert.svh
`include "tlv_stream_parser_crc_check_top_assert.svh"

module tspc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result holds
	`TSPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// every accepted request is followed by a valid result on the result side
	`TSPC_ASSERT_IMPLY(a_in_to_out, clk, arst_n, s_tvalid && s_tready, ##2 m_tvalid)

	// type bytes carry no offset or length
	`TSPC_ASSERT_IMPLY(a_type_clean, clk, arst_n, m_tvalid && m_tuser == tspc_pkg::ROLE_TYPE, m_tdata[51:20] == 32'd0)

	// a record only completes on its length low byte or a value byte
	`TSPC_ASSERT_IMPLY(a_done_role, clk, arst_n, m_tvalid && m_tdata[52], m_tuser == tspc_pkg::ROLE_LEN_LO || m_tuser == tspc_pkg::ROLE_VALUE)

endmodule

bind tlv_stream_parser_crc_check_top tspc_checker u_tspc_checker (.*);
